// ===== src/assert_macros.svh =====
// Assertion macros shared by the point suppression modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Relation that must hold at every clock edge outside reset.
`define PCDS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");

// Implication checked at every clock edge outside reset.
`define PCDS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Consequence that must hold in the cycle after the antecedent.
`define PCDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check violated");

`endif

// ===== src/pcds_pkg.sv =====
// Shared types and constants of the point suppression block.
package pcds_pkg;

    localparam int MAX_KEPT   = 64;
    localparam int COORD_BITS = 12;
    localparam int ARM_BITS   = 6;
    localparam int OFS_BITS   = 12;
    localparam int CFG_BITS   = 12;
    localparam int OUTX_BITS  = 13;
    localparam int CNT_BITS   = $clog2(MAX_KEPT + 1);
    localparam int IDX_BITS   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    localparam logic [ARM_BITS-1:0] ARM_RESET = ARM_BITS'(10);
    localparam logic [OFS_BITS-1:0] OFS_RESET = OFS_BITS'(1200);
    localparam logic [CNT_BITS-1:0] CNT_MAX   = CNT_BITS'(MAX_KEPT);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [IDX_BITS-1:0]   idx_t;

    typedef enum logic [0:0] {
        CFG_ARM_LENGTH = 1'b0,
        CFG_X_OFFSET   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

// ===== src/pcds_ctrl.sv =====
// Sequencing state machine of the point suppression block.
`include "assert_macros.svh"

module pcds_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pcds_pkg::status_t st,
    output pcds_pkg::cmd_t    cmd
);
    import pcds_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (st.scan_done)
                begin
                    if (st.out_free)
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PCDS_ASSERT_IMPL(a_commit_needs_room, cmd.commit, st.out_free && st.scan_done)
    `PCDS_ASSERT_NEXT(a_load_starts_scan, cmd.load, state_reg == ST_SCAN)

endmodule

// ===== src/pcds_dp.sv =====
// Datapath of the point suppression block: point store, comparator, output register.
`include "assert_macros.svh"

module pcds_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [pcds_pkg::CFG_BITS-1:0]   cfg_data,
    input  pcds_pkg::coord_t                point_x,
    input  pcds_pkg::coord_t                point_y,
    input  logic                            last_point,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pcds_pkg::OUTX_BITS-1:0]  out_x,
    output pcds_pkg::coord_t                out_y,
    output logic                            kept,
    output logic                            store_full,
    output logic                            list_end,
    input  pcds_pkg::cmd_t                  cmd,
    output pcds_pkg::status_t               st
);
    import pcds_pkg::*;

    logic [ARM_BITS-1:0] arm_reg;
    logic [OFS_BITS-1:0] ofs_reg;

    coord_t x_reg;
    coord_t y_reg;
    logic   last_reg;

    cnt_t count_reg;
    cnt_t count_next;
    cnt_t rd_idx_reg;
    logic rd_pend_reg;
    logic hit_reg;

    coord_t kept_x_mem [0:MAX_KEPT-1];
    coord_t kept_y_mem [0:MAX_KEPT-1];
    coord_t rd_x_reg;
    coord_t rd_y_reg;

    logic out_valid_reg;
    logic [OUTX_BITS-1:0] out_x_reg;
    coord_t out_y_reg;
    logic   kept_reg;
    logic   full_reg;
    logic   list_end_reg;

    logic   issue;
    logic   near;
    logic   keep_now;
    logic   room;
    coord_t dx;
    coord_t dy;
    logic [ARM_BITS:0] twice;

    // One read of the store per cycle while scanning, stopped early on a hit.
    assign issue    = cmd.scan && !hit_reg && (rd_idx_reg != count_reg);
    assign keep_now = !hit_reg;
    assign room     = (count_reg != CNT_MAX);

    assign dx    = (x_reg >= rd_x_reg) ? (x_reg - rd_x_reg) : (rd_x_reg - x_reg);
    assign dy    = (y_reg >= rd_y_reg) ? (y_reg - rd_y_reg) : (rd_y_reg - y_reg);
    assign twice = {arm_reg, 1'b0};

    always_comb
    begin
        near = ((dy == '0) && (dx <= COORD_BITS'(twice)))
            || ((dx == '0) && (dy <= COORD_BITS'(twice)))
            || ((dx <= COORD_BITS'(arm_reg)) && (dy <= COORD_BITS'(arm_reg)));
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit)
        begin
            if (last_reg)
            begin
                count_next = '0;
            end
            else if (keep_now && room)
            begin
                count_next = count_reg + cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_reg       <= ARM_RESET;
            ofs_reg       <= OFS_RESET;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ARM_LENGTH: arm_reg <= cfg_data[ARM_BITS-1:0];
                    CFG_X_OFFSET:   ofs_reg <= cfg_data[OFS_BITS-1:0];
                    default:        arm_reg <= arm_reg;
                endcase
            end

            count_reg <= count_next;

            if (cmd.load)
            begin
                rd_idx_reg  <= '0;
                rd_pend_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end
            else
            begin
                rd_pend_reg <= issue;
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + cnt_t'(1);
                end
                if (cmd.scan && rd_pend_reg && near)
                begin
                    hit_reg <= 1'b1;
                end
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Store and payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= point_x;
            y_reg    <= point_y;
            last_reg <= last_point;
        end
        if (issue)
        begin
            rd_x_reg <= kept_x_mem[rd_idx_reg[IDX_BITS-1:0]];
            rd_y_reg <= kept_y_mem[rd_idx_reg[IDX_BITS-1:0]];
        end
        if (cmd.commit && keep_now && room)
        begin
            kept_x_mem[count_reg[IDX_BITS-1:0]] <= x_reg;
            kept_y_mem[count_reg[IDX_BITS-1:0]] <= y_reg;
        end
        if (cmd.commit)
        begin
            out_x_reg    <= OUTX_BITS'(x_reg) + OUTX_BITS'(ofs_reg);
            out_y_reg    <= y_reg;
            kept_reg     <= keep_now;
            full_reg     <= keep_now && !room;
            list_end_reg <= last_reg;
        end
    end

    assign st.scan_done = hit_reg || ((rd_idx_reg == count_reg) && !rd_pend_reg);
    assign st.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign kept       = kept_reg;
    assign store_full = full_reg;
    assign list_end   = list_end_reg;

    `PCDS_ASSERT_ALWAYS(a_count_bounded, count_reg <= CNT_MAX)
    `PCDS_ASSERT_IMPL(a_scan_within_store, cmd.scan, rd_idx_reg <= count_reg)
    `PCDS_ASSERT_NEXT(a_list_end_clears, cmd.commit && last_reg, count_reg == '0)

endmodule

// ===== src/point_cross_duplicate_suppress.sv =====
// Top level of the point suppression block: controller plus datapath.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    point_x, point_y, last_point
//   result    out        out_valid / out_ready  out_x, out_y, kept, store_full, list_end
//   config    in         cfg_wr_en              cfg_index, cfg_data
//
// One item at a time: once an item is accepted, the points stored for the current
// list (0 to 64 of them) are scanned through the single read port of the point
// store, one entry per cycle, and then the result is committed; a close match
// ends the scan early.
// Reset clears the store count and the handshake state and loads the default
// arm length and x offset. A stalled result waits in the output register while
// the next item is already accepted and scanned; that item's result is committed
// once the output register frees up.
module point_cross_duplicate_suppress (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [pcds_pkg::CFG_BITS-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  pcds_pkg::coord_t                point_x,
    input  pcds_pkg::coord_t                point_y,
    input  logic                            last_point,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pcds_pkg::OUTX_BITS-1:0]  out_x,
    output pcds_pkg::coord_t                out_y,
    output logic                            kept,
    output logic                            store_full,
    output logic                            list_end
);
    import pcds_pkg::*;

    // Commands from the controller and status back from the datapath.
    cmd_t    cmd;
    status_t st;

    // The controller accepts an item only when idle, then scans the store and
    // commits the result as soon as the output register can take it.
    pcds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the stored points, the proximity
    // comparator and the output register.
    pcds_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .kept       (kept),
        .store_full (store_full),
        .list_end   (list_end),
        .cmd        (cmd),
        .st         (st)
    );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the point_cross_duplicate_suppress block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcds_pkg::*;

    // Cycle limit for the whole run; it leaves room for full scans and stalls on
    // both sides.
    localparam int CYCLE_LIMIT = 600000;
    localparam int PLAN_LEN    = 25;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 88;

    // One verdict per accepted point: the fields of the result item.
    typedef struct packed {
        logic [OUTX_BITS-1:0] ox;
        coord_t               oy;
        logic                 kept;
        logic                 full;
        logic                 list_end;
    } point_verdict_t;

    // The directed part is a list of rows. A point row may carry a typed
    // out_x, kept and store_full; a fill row sends a run of distinct points
    // along one line; a config row writes both registers.
    typedef enum int {ROW_POINT, ROW_CONFIG, ROW_FILL} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        int        a;        // x, arm length, or number of fill points
        int        b;        // y, x offset, or the y of the fill line
        bit        is_last;
        bit        pinned;
        int        ox;
        bit        kp;
        bit        fl;
    } stim_row_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic                  cfg_index  = 1'b0;
    logic [CFG_BITS-1:0]   cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    coord_t                point_x    = '0;
    coord_t                point_y    = '0;
    logic                  last_point = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [OUTX_BITS-1:0]  out_x;
    coord_t                out_y;
    logic                  kept;
    logic                  store_full;
    logic                  list_end;

    point_cross_duplicate_suppress DUT (.*);

    // Directed rows. The first ten run with the reset settings (arm 10,
    // offset 1200), so their typed results also confirm the reset values.
    stim_row_t plan [PLAN_LEN] = '{
        // Arm 10: first point of a list is always kept.
        '{ROW_POINT,  100,  100, 1'b0, 1'b1, 1300, 1'b1, 1'b0},
        // Same row, exactly twice the arm away: dropped.
        '{ROW_POINT,  120,  100, 1'b0, 1'b1, 1320, 1'b0, 1'b0},
        // Same row, one past twice the arm: kept.
        '{ROW_POINT,  121,  100, 1'b0, 1'b1, 1321, 1'b1, 1'b0},
        // Same column, twice the arm away: dropped.
        '{ROW_POINT,  100,   80, 1'b0, 1'b1, 1300, 1'b0, 1'b0},
        // Corner of the square of side twice the arm: dropped.
        '{ROW_POINT,  110,  110, 1'b0, 1'b1, 1310, 1'b0, 1'b0},
        '{ROW_POINT,   89,  111, 1'b0, 1'b0,    0, 1'b0, 1'b0},
        // Coordinate extremes.
        '{ROW_POINT, 4095, 4095, 1'b0, 1'b1, 5295, 1'b1, 1'b0},
        '{ROW_POINT,    0,    0, 1'b0, 1'b1, 1200, 1'b1, 1'b0},
        '{ROW_POINT, 4095,    0, 1'b1, 1'b1, 5295, 1'b1, 1'b0},
        // The list ended, so the same point is kept again.
        '{ROW_POINT,  100,  100, 1'b0, 1'b1, 1300, 1'b1, 1'b0},
        // Arm zero and the largest offset: only exact repeats are dropped.
        '{ROW_CONFIG,   0, 4095, 1'b0, 1'b0,    0, 1'b0, 1'b0},
        '{ROW_POINT,  100,  100, 1'b0, 1'b1, 4195, 1'b0, 1'b0},
        '{ROW_POINT, 4095, 4095, 1'b0, 1'b1, 8190, 1'b1, 1'b0},
        '{ROW_POINT,  101,  100, 1'b1, 1'b1, 4196, 1'b1, 1'b0},
        // Fill the store with a fresh list of distinct points.
        '{ROW_FILL,    64, 3000, 1'b0, 1'b0,    0, 1'b0, 1'b0},
        // Store full: kept but not stored, so a repeat is kept once more,
        // while a repeat of a stored point is still dropped.
        '{ROW_POINT, 4000,  100, 1'b0, 1'b1, 8095, 1'b1, 1'b1},
        '{ROW_POINT,    0, 3000, 1'b0, 1'b1, 4095, 1'b0, 1'b0},
        '{ROW_POINT, 4000,  100, 1'b1, 1'b1, 8095, 1'b1, 1'b1},
        // Largest arm and no offset.
        '{ROW_CONFIG,  63,    0, 1'b0, 1'b0,    0, 1'b0, 1'b0},
        '{ROW_POINT, 2000, 2000, 1'b0, 1'b1, 2000, 1'b1, 1'b0},
        '{ROW_POINT, 2126, 2000, 1'b0, 1'b1, 2126, 1'b0, 1'b0},
        '{ROW_POINT, 2127, 2000, 1'b0, 1'b1, 2127, 1'b1, 1'b0},
        '{ROW_POINT, 2063, 2063, 1'b0, 1'b1, 2063, 1'b0, 1'b0},
        '{ROW_POINT, 2064, 1936, 1'b0, 1'b0,    0, 1'b0, 1'b0},
        '{ROW_POINT, 2000, 2126, 1'b1, 1'b1, 2000, 1'b0, 1'b0}
    };

    // Shadow of the block: stored points of the current list and registers.
    coord_t              held_x [MAX_KEPT];
    coord_t              held_y [MAX_KEPT];
    int                  held_count = 0;
    logic [ARM_BITS-1:0] arm_len    = 6'd10;
    logic [OFS_BITS-1:0] shift_x    = 12'd1200;

    point_verdict_t      pending_verdicts [$];
    point_verdict_t      fresh_verdict;
    point_verdict_t      oldest_verdict;

    // Typed result of the point currently on the input, if any.
    bit                   pin_active = 1'b0;
    logic [OUTX_BITS-1:0] pin_ox     = '0;
    bit                   pin_kept   = 1'b0;
    bit                   pin_full   = 1'b0;

    // Arm length as last written, used to aim random points at the edges.
    int  dial_arm     = 10;
    // While calm is set neither side inserts idle cycles.
    bit  calm         = 1'b0;
    int  errors       = 0;
    int  cycle_count  = 0;
    int  n_items      = 0;
    int  n_kept       = 0;
    int  n_dropped    = 0;
    int  n_overflow   = 0;
    int  n_lists      = 0;
    int  n_settings   = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Works out the result of one point and updates the shadow store.
    // A point is dropped when a stored point lies on its row within twice
    // the arm, on its column within twice the arm, or in the square of
    // half-side one arm around it.
    function automatic point_verdict_t judge_point(coord_t x, coord_t y, logic is_last);
        point_verdict_t v;
        int dx;
        int dy;
        int twice;
        bit near;
        near  = 1'b0;
        twice = 2 * int'(arm_len);
        for (int i = 0; i < held_count; i++)
        begin
            dx = (x >= held_x[i]) ? int'(x) - int'(held_x[i]) : int'(held_x[i]) - int'(x);
            dy = (y >= held_y[i]) ? int'(y) - int'(held_y[i]) : int'(held_y[i]) - int'(y);
            if ((dy == 0 && dx <= twice) || (dx == 0 && dy <= twice) ||
                (dx <= int'(arm_len) && dy <= int'(arm_len)))
                near = 1'b1;
        end
        v.ox       = {1'b0, x} + {1'b0, shift_x};
        v.oy       = y;
        v.kept     = !near;
        v.full     = 1'b0;
        v.list_end = is_last;
        if (!near)
        begin
            if (held_count < MAX_KEPT)
            begin
                held_x[held_count] = x;
                held_y[held_count] = y;
                held_count++;
            end
            else
                v.full = 1'b1;
        end
        if (is_last)
            held_count = 0;
        return v;
    endfunction

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    function automatic coord_t clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return 12'd4095;
        return coord_t'(v);
    endfunction

    // Moves a coordinate by the given distance in a random direction.
    function automatic coord_t nudge(coord_t base, int span);
        return $urandom_range(1) ? clamp_coord(int'(base) + span)
                                 : clamp_coord(int'(base) - span);
    endfunction

    // Cycle watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("point_cross_duplicate_suppress regression: fail");
            $finish;
        end
    end

    // The receiver stalls on its own schedule, except while calm.
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 22);
    end

    // Everything that happens at a clock edge is observed here: results are
    // checked against the oldest verdict, accepted points are judged, and
    // register writes reach the shadow copy. Values read here are the ones
    // from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: result with no item outstanding, expected none, got x %0d y %0d",
                             $time, out_x, out_y);
                    errors++;
                end
                else
                begin
                    oldest_verdict = pending_verdicts.pop_front();
                    check_field("out_x", 16'(oldest_verdict.ox), 16'(out_x));
                    check_field("out_y", 16'(oldest_verdict.oy), 16'(out_y));
                    check_field("kept", 16'(oldest_verdict.kept), 16'(kept));
                    check_field("store_full", 16'(oldest_verdict.full), 16'(store_full));
                    check_field("list_end", 16'(oldest_verdict.list_end), 16'(list_end));
                end
                if (kept === 1'b1)
                    n_kept++;
                else
                    n_dropped++;
                if (store_full === 1'b1)
                    n_overflow++;
                if (list_end === 1'b1)
                    n_lists++;
            end
            if (in_valid && in_ready)
            begin
                fresh_verdict = judge_point(point_x, point_y, last_point);
                // Where a row gives its result by hand, that result is the
                // one the block must produce.
                if (pin_active)
                begin
                    fresh_verdict.ox   = pin_ox;
                    fresh_verdict.kept = pin_kept;
                    fresh_verdict.full = pin_full;
                end
                pending_verdicts = {pending_verdicts, fresh_verdict};
                n_items++;
            end
            if (cfg_wr_en)
            begin
                if (cfg_idx_t'(cfg_index) == CFG_ARM_LENGTH)
                    arm_len = cfg_data[ARM_BITS-1:0];
                else
                    shift_x = cfg_data[OFS_BITS-1:0];
            end
        end
    end

    // Offers one point and returns at the edge where it is taken. Any idle
    // gap is placed before the point, so valid is never dropped once raised.
    task automatic send_point(coord_t x, coord_t y, logic is_last, bit pinned,
                              logic [OUTX_BITS-1:0] ox, bit kp, bit fl);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(99) < 22)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        point_x    <= x;
        point_y    <= y;
        last_point <= is_last;
        pin_active = pinned;
        pin_ox     = ox;
        pin_kept   = kp;
        pin_full   = fl;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Holds the input off until every outstanding result has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes both registers, arm length then x offset, while the block is idle.
    task automatic set_config(int arm, int ofs);
        wait_drained();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ARM_LENGTH;
        cfg_data  <= CFG_BITS'(arm);
        @(negedge clk);
        cfg_index <= CFG_X_OFFSET;
        cfg_data  <= CFG_BITS'(ofs);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        dial_arm = arm;
        n_settings++;
    endtask

    // Sends one list. Most points of a short list are aimed just inside or
    // just outside the suppression region of an earlier point of the same
    // list; a spread list is mostly fresh points, enough to fill the store.
    task automatic run_list(int length, bit spread);
        coord_t ax [$];
        coord_t ay [$];
        coord_t x;
        coord_t y;
        int     k;
        int     r;
        int     d;
        for (int i = 0; i < length; i++)
        begin
            r = $urandom_range(99);
            if (ax.size() == 0 || r < (spread ? 90 : 25))
            begin
                x = coord_t'($urandom_range(4095));
                y = coord_t'($urandom_range(4095));
            end
            else
            begin
                k = $urandom_range(ax.size() - 1);
                d = int'($urandom_range(2)) - 1;
                if (r < 45)
                begin
                    y = ay[k];
                    x = nudge(ax[k], 2 * dial_arm + d);
                end
                else if (r < 65)
                begin
                    x = ax[k];
                    y = nudge(ay[k], 2 * dial_arm + d);
                end
                else if (r < 90)
                begin
                    x = nudge(ax[k], dial_arm + d);
                    y = nudge(ay[k], dial_arm + int'($urandom_range(2)) - 1);
                end
                else
                begin
                    x = ax[k];
                    y = ay[k];
                end
            end
            ax = {ax, x};
            ay = {ay, y};
            send_point(x, y, i == length - 1, 1'b0, '0, 1'b0, 1'b0);
        end
    endtask

    initial begin
        int  arm;
        int  ofs;
        int  sent;
        int  lists;
        int  n;
        bit  spread;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows.
        for (int r = 0; r < PLAN_LEN; r++)
        begin
            case (plan[r].kind)
                ROW_CONFIG:
                    set_config(plan[r].a, plan[r].b);
                ROW_FILL:
                    for (int i = 0; i < plan[r].a; i++)
                        send_point(coord_t'(i * 60), coord_t'(plan[r].b), 1'b0,
                                   1'b0, '0, 1'b0, 1'b0);
                default:
                    send_point(coord_t'(plan[r].a), coord_t'(plan[r].b), plan[r].is_last,
                               plan[r].pinned, OUTX_BITS'(plan[r].ox), plan[r].kp,
                               plan[r].fl);
            endcase
        end

        // Random phases, each under its own settings. The first runs with no
        // idle cycles on either side; two phases use the register extremes.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            arm = $urandom_range(63);
            ofs = $urandom_range(4095);
            if (ph == 1)
            begin
                arm = 0;
                ofs = 0;
            end
            if (ph == 2)
            begin
                arm = 63;
                ofs = 4095;
            end
            set_config(arm, ofs);
            calm  = (ph == 0);
            sent  = 0;
            lists = 0;
            while (sent < PHASE_ITEMS)
            begin
                spread = (lists == 0 && (ph == 1 || ph == 4)) || $urandom_range(29) == 0;
                n = spread ? $urandom_range(66, 80) : $urandom_range(1, 24);
                run_list(n, spread);
                sent += n;
                lists++;
                // Now and then the sender waits for the block to empty.
                if ($urandom_range(9) == 0)
                    wait_drained();
            end
        end
        calm = 1'b0;

        // Let the last results out, then watch for strays over one full scan.
        wait_drained();
        repeat (MAX_KEPT + 8) @(posedge clk);

        $display("Ran %0d points in %0d lists under %0d register settings.",
                 n_items, n_lists, n_settings + 1);
        $display("Results: %0d kept, %0d dropped, %0d kept while the store was full.",
                 n_kept, n_dropped, n_overflow);
        if (errors == 0)
            $display("point_cross_duplicate_suppress regression: pass");
        else
            $display("point_cross_duplicate_suppress regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/pcds_pkg.sv
src/pcds_ctrl.sv
src/pcds_dp.sv
src/point_cross_duplicate_suppress.sv
tb/sv/tb.sv
